@@ design/vdm_pkg.sv @@
// ----------------------------------------------------------------------------
// vdm_pkg
// Widths, sequencer states and shared constants of the vector distance block.
// ----------------------------------------------------------------------------
package vdm_pkg;

  localparam int ELEM_W     = 32;
  localparam int DIFF_W     = 33;
  localparam int SQUARE_W   = 64;
  localparam int ABS_W      = 48;
  localparam int MAX_W      = 33;
  localparam int RATIO_W    = 32;
  localparam int EUCLID_W   = 32;
  localparam int CU_W       = 65;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_RATIO,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

@@ design/vdm_channels.sv @@
// ----------------------------------------------------------------------------
// vdm_channels
// Ready/valid channels for element pairs in and distance results out.
// ----------------------------------------------------------------------------
interface vdm_in_if import vdm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] elem_a;
  logic signed [ELEM_W-1:0] elem_b;
  logic                     last_pair;

  modport source (output valid, elem_a, elem_b, last_pair, input ready);
  modport sink   (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface vdm_out_if import vdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [EUCLID_W-1:0]   euclid_dist;
  logic [ABS_W-1:0]      manhattan_dist;
  logic [MAX_W-1:0]      chebyshev_dist;
  logic [RATIO_W-1:0]    canberra_dist;

  modport source (output valid, euclid_dist, manhattan_dist, chebyshev_dist,
                  canberra_dist, input ready);
  modport sink   (input valid, euclid_dist, manhattan_dist, chebyshev_dist,
                  canberra_dist, output ready);
endinterface

@@ design/vdm_cmpsub.sv @@
// ----------------------------------------------------------------------------
// vdm_cmpsub
// Shared compare-and-subtract unit used by the divider and the square root.
// ----------------------------------------------------------------------------
module vdm_cmpsub import vdm_pkg::*; (
  input  logic [CU_W-1:0] minuend,
  input  logic [CU_W-1:0] subtrahend,
  output logic            ge,
  output logic [CU_W-1:0] diff
);

  logic [CU_W:0] wide;

  assign wide = {1'b0, minuend} - {1'b0, subtrahend};
  assign ge   = ~wide[CU_W];
  assign diff = wide[CU_W-1:0];

endmodule

@@ design/vector_distance_metrics.sv @@
// ----------------------------------------------------------------------------
// vector_distance_metrics
// Euclidean, Manhattan, Chebyshev and Canberra distances over streamed pairs.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  pairs   | in        | elem_a, elem_b (signed fixed point), last_pair
//  dists   | out       | euclid_dist, manhattan_dist, chebyshev_dist, canberra_dist
//
//  An accepted pair runs PREP, MUL, ACC, DIV (skipped when both elements are
//  zero) and RATIO before the next pair is taken; the restoring divider
//  produces one quotient bit per cycle in the shared compare-subtract unit.
//  A final pair adds 32 square root steps in the same unit, then the load of
//  the output register, which waits while an earlier result is still held
//  there. Synchronous reset clears the sequencer, the accumulators and the
//  output valid flag.
// ----------------------------------------------------------------------------
module vector_distance_metrics import vdm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  vdm_in_if.sink    pairs,
  vdm_out_if.source dists
);

  localparam int QUO_W = FRAC_BITS + 1;
  localparam int CNT_W = $clog2((QUO_W > SQRT_STEPS) ? QUO_W : SQRT_STEPS);
  localparam int REM_W = DIFF_W;

  state_t state;
  state_t state_next;

  logic signed [ELEM_W-1:0] a_r;
  logic signed [ELEM_W-1:0] b_r;
  logic                     last_r;
  logic [DIFF_W-1:0]        diff_r;
  logic [DIFF_W-1:0]        den_r;
  logic [SQUARE_W-1:0]      sq_r;

  logic [SQUARE_W-1:0] sum_squares;
  logic [ABS_W-1:0]    sum_absolute;
  logic [MAX_W-1:0]    max_absolute;
  logic [RATIO_W-1:0]  ratio_sum;

  logic [REM_W-1:0]    rem;
  logic [QUO_W-1:0]    dlow;
  logic [QUO_W-1:0]    quo;
  logic [CNT_W-1:0]    cnt;
  logic [SQUARE_W-1:0] root_x;
  logic [SQUARE_W-1:0] root_res;
  logic [SQUARE_W-1:0] root_bit;

  logic            in_ready;
  logic            out_free;
  logic            out_load;
  logic [CU_W-1:0] cu_a;
  logic [CU_W-1:0] cu_b;
  logic            cu_ge;
  logic [CU_W-1:0] cu_diff;

  logic signed [DIFF_W-1:0] sub_ab;
  logic [DIFF_W-1:0]        abs_ab;
  logic [ELEM_W-1:0]        mag_a;
  logic [ELEM_W-1:0]        mag_b;
  logic [SQUARE_W-1:0]      prod;
  logic [SQUARE_W:0]        sq_add;
  logic [ABS_W:0]           abs_add;
  logic [RATIO_W:0]         ratio_add;
  logic [REM_W:0]           rem_shift;
  logic [SQUARE_W-1:0]      root_try;

  vdm_cmpsub u_cmpsub (
    .minuend    (cu_a),
    .subtrahend (cu_b),
    .ge         (cu_ge),
    .diff       (cu_diff)
  );

  assign sub_ab    = {a_r[ELEM_W-1], a_r} - {b_r[ELEM_W-1], b_r};
  assign abs_ab    = sub_ab[DIFF_W-1] ? DIFF_W'(-sub_ab) : DIFF_W'(sub_ab);
  assign mag_a     = a_r[ELEM_W-1] ? ELEM_W'(-a_r) : ELEM_W'(a_r);
  assign mag_b     = b_r[ELEM_W-1] ? ELEM_W'(-b_r) : ELEM_W'(b_r);
  assign prod      = SQUARE_W'(diff_r[ELEM_W-1:0]) * SQUARE_W'(diff_r[ELEM_W-1:0]);
  assign sq_add    = {1'b0, sum_squares} + {1'b0, sq_r};
  assign abs_add   = {1'b0, sum_absolute} + (ABS_W + 1)'(diff_r);
  assign ratio_add = {1'b0, ratio_sum} + (RATIO_W + 1)'(quo);
  assign rem_shift = {rem, dlow[QUO_W-1]};
  assign root_try  = root_res + root_bit;
  assign out_free  = ~dists.valid | dists.ready;
  assign pairs.ready = in_ready;

  always_comb begin
    cu_a = '0;
    cu_b = '0;
    unique case (state)
      ST_DIV: begin
        cu_a = CU_W'(rem_shift);
        cu_b = CU_W'(den_r);
      end
      ST_SQRT: begin
        cu_a = CU_W'(root_x);
        cu_b = CU_W'(root_try);
      end
      default: begin
        cu_a = '0;
        cu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (pairs.valid) state_next = ST_PREP;
      ST_PREP:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = (den_r != '0) ? ST_DIV : ST_RATIO;
      ST_DIV:   if (cnt == '0) state_next = ST_RATIO;
      ST_RATIO: state_next = last_r ? ST_SQRT : ST_IDLE;
      ST_SQRT:  if (cnt == '0) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_load = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_squares  <= '0;
      sum_absolute <= '0;
      max_absolute <= '0;
      ratio_sum    <= '0;
    end else begin
      unique case (state)
        ST_ACC: begin
          sum_squares  <= sq_add[SQUARE_W] ? '1 : sq_add[SQUARE_W-1:0];
          sum_absolute <= abs_add[ABS_W] ? '1 : abs_add[ABS_W-1:0];
          if (diff_r > max_absolute) begin
            max_absolute <= diff_r;
          end
        end
        ST_RATIO: begin
          ratio_sum <= ratio_add[RATIO_W] ? '1 : ratio_add[RATIO_W-1:0];
        end
        ST_DONE: begin
          if (out_free) begin
            sum_squares  <= '0;
            sum_absolute <= '0;
            max_absolute <= '0;
            ratio_sum    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pairs.valid) begin
          a_r    <= pairs.elem_a;
          b_r    <= pairs.elem_b;
          last_r <= pairs.last_pair;
        end
      end
      ST_PREP: begin
        diff_r <= abs_ab;
        den_r  <= DIFF_W'(mag_a) + DIFF_W'(mag_b);
      end
      ST_MUL: begin
        sq_r <= diff_r[DIFF_W-1] ? '1 : prod;
      end
      ST_ACC: begin
        rem  <= REM_W'(diff_r[DIFF_W-1:1]);
        dlow <= {diff_r[0], FRAC_BITS'(0)};
        quo  <= '0;
        cnt  <= CNT_W'(FRAC_BITS);
      end
      ST_DIV: begin
        rem  <= cu_ge ? cu_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
        dlow <= dlow << 1;
        quo  <= {quo[QUO_W-2:0], cu_ge};
        cnt  <= cnt - 1'b1;
      end
      ST_RATIO: begin
        root_x   <= sum_squares;
        root_res <= '0;
        root_bit <= SQUARE_W'(1) << (SQUARE_W - 2);
        cnt      <= CNT_W'(SQRT_STEPS - 1);
      end
      ST_SQRT: begin
        if (cu_ge) begin
          root_x   <= cu_diff[SQUARE_W-1:0];
          root_res <= (root_res >> 1) + root_bit;
        end else begin
          root_res <= root_res >> 1;
        end
        root_bit <= root_bit >> 2;
        cnt      <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dists.valid <= 1'b0;
    end else if (out_load) begin
      dists.valid <= 1'b1;
    end else if (dists.ready) begin
      dists.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dists.euclid_dist    <= root_res[EUCLID_W-1:0];
      dists.manhattan_dist <= sum_absolute;
      dists.chebyshev_dist <= max_absolute;
      dists.canberra_dist  <= ratio_sum;
    end
  end

`ifndef SYNTHESIS
  // A new result only appears after the sequencer has finished a final pair.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(dists.valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a finished final pair");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (REM_W'(rem) < den_r))
    else $error("divider remainder reached the divisor");

  // A Canberra term never exceeds one.
  a_term_at_most_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RATIO) |-> (quo <= (QUO_W'(1) << FRAC_BITS)))
    else $error("Canberra term above one");

  // The largest difference never exceeds the sum of differences.
  a_max_within_sum: assert property (@(posedge clk) disable iff (rst)
    (ABS_W'(max_absolute) <= sum_absolute))
    else $error("largest difference exceeds the sum of differences");

  // Loading a result leaves every accumulator cleared.
  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (sum_squares == '0 && sum_absolute == '0 &&
                  max_absolute == '0 && ratio_sum == '0))
    else $error("accumulators not cleared after a result");
`endif

endmodule
